### rtl/core/set_assoc_lru_cache_sim_defines.svh
// ----------------------------------------------------------------------------
// Set-associative LRU cache: assertion macros
// Shared macros for the concurrent checks on the cache ports.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_SIM_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_SIM_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SALC_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Cache port check failed.");

// Checks that the consequent holds in the cycle after the antecedent.
`define SALC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Cache port check failed.");

`endif

### rtl/core/salc_pkg.sv
// ----------------------------------------------------------------------------
// Set-associative LRU cache package
// Widths, register indexes, outcome codes and controller interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

  localparam int MAX_SET_BITS_DEF = 5;
  localparam int WAYS_DEF         = 4;

  localparam int ADDR_W        = 64;
  localparam int CNT_W         = 32;
  localparam int SET_BITS_W    = 3;
  localparam int BLOCK_BITS_W  = 6;
  localparam int WAYS_IN_USE_W = 3;
  localparam int CFG_DATA_W    = 6;
  localparam int CFG_INDEX_W   = 2;
  localparam int OUTCOME_W     = 2;
  localparam int WAY_OUT_W     = 2;

  localparam logic [BLOCK_BITS_W-1:0] MAX_BLOCK_BITS = 6'd32;

  localparam logic [SET_BITS_W-1:0]    SET_BITS_RST    = 3'd4;
  localparam logic [BLOCK_BITS_W-1:0]  BLOCK_BITS_RST  = 6'd4;
  localparam logic [WAYS_IN_USE_W-1:0] WAYS_IN_USE_RST = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BITS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WAYS_IN_USE = 2'd2;

  localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_FILL  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

  typedef struct packed {
    logic clear;
    logic load;
    logic commit;
  } salc_cmd_t;

  typedef struct packed {
    logic clear_last;
  } salc_status_t;

endpackage

`default_nettype wire

### rtl/core/salc_datapath.sv
// ----------------------------------------------------------------------------
// Set-associative LRU cache datapath
// Configuration registers, set memories, lookup, victim choice and counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module salc_datapath #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int WAYS         = salc_pkg::WAYS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [salc_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  wire logic [salc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire logic [salc_pkg::ADDR_W-1:0]           addr_i,
  input  wire salc_pkg::salc_cmd_t                   cmd_i,
  output salc_pkg::salc_status_t                     status_o,
  output logic [salc_pkg::OUTCOME_W-1:0]             outcome_o,
  output logic [salc_pkg::WAY_OUT_W-1:0]             way_used_o,
  output logic [salc_pkg::CNT_W-1:0]                 hit_count_o,
  output logic [salc_pkg::CNT_W-1:0]                 miss_count_o,
  output logic [salc_pkg::CNT_W-1:0]                 evict_count_o
);

  localparam int SETS = 1 << MAX_SET_BITS;
  localparam int SIW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RW   = WW;
  localparam int NWW  = $clog2(WAYS + 1);
  localparam int AW   = salc_pkg::ADDR_W;
  localparam int SBW  = salc_pkg::SET_BITS_W + 1 + salc_pkg::BLOCK_BITS_W;
  localparam logic [RW-1:0] MAX_RANK = RW'(WAYS - 1);

  logic [salc_pkg::SET_BITS_W-1:0]    set_bits_q;
  logic [salc_pkg::BLOCK_BITS_W-1:0]  block_bits_q;
  logic [salc_pkg::WAYS_IN_USE_W-1:0] ways_q;

  logic [salc_pkg::SET_BITS_W-1:0]   s_eff;
  logic [salc_pkg::BLOCK_BITS_W-1:0] b_eff;
  logic [NWW-1:0]                    nways_eff;
  logic [WAYS-1:0]                   use_w;

  logic [AW-1:0]  shifted;
  logic [SIW-1:0] index_mask;
  logic [SIW-1:0] set_idx;
  logic [SBW-1:0] tag_shift;
  logic [AW-1:0]  tag_in;

  logic [WAYS-1:0]                valid_mem [SETS];
  logic [WAYS-1:0][RW-1:0]        rank_mem  [SETS];
  logic [WAYS-1:0][AW-1:0]        tag_mem   [SETS];

  logic [WAYS-1:0]         valid_rd_q;
  logic [WAYS-1:0][RW-1:0] rank_rd_q;
  logic [WAYS-1:0][AW-1:0] tag_rd_q;
  logic [AW-1:0]           tag_q;
  logic [SIW-1:0]          set_q;
  logic [SIW-1:0]          clr_q;

  logic [WAYS-1:0] match;
  logic            hit;
  logic [WW-1:0]   hit_way;
  logic            found_free;
  logic [WW-1:0]   free_way;
  logic [WW-1:0]   victim_way;
  logic [RW-1:0]   best_rank;
  logic [WW-1:0]   way;
  logic [WAYS-1:0]         valid_new;
  logic [WAYS-1:0][RW-1:0] rank_new;
  logic [WAYS-1:0][AW-1:0] tag_new;
  logic [salc_pkg::OUTCOME_W-1:0] outcome_d;

  logic [salc_pkg::OUTCOME_W-1:0] outcome_q;
  logic [salc_pkg::WAY_OUT_W-1:0] way_q;
  logic [salc_pkg::CNT_W-1:0]     hits_q;
  logic [salc_pkg::CNT_W-1:0]     misses_q;
  logic [salc_pkg::CNT_W-1:0]     evicts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= salc_pkg::SET_BITS_RST;
      block_bits_q <= salc_pkg::BLOCK_BITS_RST;
      ways_q       <= salc_pkg::WAYS_IN_USE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        salc_pkg::REG_SET_BITS: begin
          set_bits_q <= cfg_data_i[salc_pkg::SET_BITS_W-1:0];
        end
        salc_pkg::REG_BLOCK_BITS: begin
          block_bits_q <= cfg_data_i[salc_pkg::BLOCK_BITS_W-1:0];
        end
        salc_pkg::REG_WAYS_IN_USE: begin
          ways_q <= cfg_data_i[salc_pkg::WAYS_IN_USE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    s_eff = (int'(set_bits_q) > MAX_SET_BITS) ? salc_pkg::SET_BITS_W'(MAX_SET_BITS)
                                             : set_bits_q;
    b_eff = (block_bits_q > salc_pkg::MAX_BLOCK_BITS) ? salc_pkg::MAX_BLOCK_BITS
                                                      : block_bits_q;
    if (ways_q == '0) begin
      nways_eff = NWW'(1);
    end else if (int'(ways_q) > WAYS) begin
      nways_eff = NWW'(WAYS);
    end else begin
      nways_eff = NWW'(ways_q);
    end
    for (int i = 0; i < WAYS; i++) begin
      use_w[i] = (i < int'(nways_eff));
    end
  end

  always_comb begin
    shifted = addr_i >> b_eff;
    for (int j = 0; j < SIW; j++) begin
      index_mask[j] = (j < int'(s_eff));
    end
    set_idx   = shifted[SIW-1:0] & index_mask;
    tag_shift = SBW'(s_eff) + SBW'(b_eff);
    tag_in    = addr_i >> tag_shift;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + SIW'(1);
    end
  end

  assign status_o.clear_last = (clr_q == SIW'(SETS - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      valid_mem[clr_q] <= '0;
      rank_mem[clr_q]  <= '0;
    end else if (cmd_i.commit) begin
      valid_mem[set_q] <= valid_new;
      rank_mem[set_q]  <= rank_new;
      tag_mem[set_q]   <= tag_new;
    end
    if (cmd_i.load) begin
      valid_rd_q <= valid_mem[set_idx];
      rank_rd_q  <= rank_mem[set_idx];
      tag_rd_q   <= tag_mem[set_idx];
      tag_q      <= tag_in;
      set_q      <= set_idx;
    end
  end

  always_comb begin
    hit_way    = '0;
    free_way   = '0;
    for (int i = 0; i < WAYS; i++) begin
      match[i] = use_w[i] && valid_rd_q[i] && (tag_rd_q[i] == tag_q);
    end
    hit        = |match;
    found_free = |(use_w & ~valid_rd_q);
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_way = WW'(i);
      end
      if (use_w[i] && !valid_rd_q[i]) begin
        free_way = WW'(i);
      end
    end
    victim_way = '0;
    best_rank  = rank_rd_q[0];
    for (int i = 1; i < WAYS; i++) begin
      if (use_w[i] && (rank_rd_q[i] > best_rank)) begin
        best_rank  = rank_rd_q[i];
        victim_way = WW'(i);
      end
    end
    if (hit) begin
      way       = hit_way;
      outcome_d = salc_pkg::OUTCOME_HIT;
    end else if (found_free) begin
      way       = free_way;
      outcome_d = salc_pkg::OUTCOME_FILL;
    end else begin
      way       = victim_way;
      outcome_d = salc_pkg::OUTCOME_EVICT;
    end
    valid_new = valid_rd_q;
    tag_new   = tag_rd_q;
    valid_new[way] = 1'b1;
    tag_new[way]   = tag_q;
    for (int i = 0; i < WAYS; i++) begin
      rank_new[i] = rank_rd_q[i];
      if (WW'(i) == way) begin
        rank_new[i] = '0;
      end else if (use_w[i] && valid_rd_q[i] && rank_rd_q[i] != MAX_RANK &&
                   (!hit || rank_rd_q[i] < rank_rd_q[way])) begin
        rank_new[i] = rank_rd_q[i] + RW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      outcome_q <= outcome_d;
      way_q     <= salc_pkg::WAY_OUT_W'(way);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
    end else if (cmd_i.commit) begin
      if (hit) begin
        hits_q <= hits_q + salc_pkg::CNT_W'(1);
      end else begin
        misses_q <= misses_q + salc_pkg::CNT_W'(1);
      end
      if (!hit && !found_free) begin
        evicts_q <= evicts_q + salc_pkg::CNT_W'(1);
      end
    end
  end

  assign outcome_o     = outcome_q;
  assign way_used_o    = way_q;
  assign hit_count_o   = hits_q;
  assign miss_count_o  = misses_q;
  assign evict_count_o = evicts_q;

endmodule

`default_nettype wire

### rtl/core/salc_controller.sv
// ----------------------------------------------------------------------------
// Set-associative LRU cache controller
// Sequences the clearing pass, the set read and the write-back of each item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module salc_controller (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  input  wire salc_pkg::salc_status_t status_i,
  output salc_pkg::salc_cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o.clear  = (state_q == ST_CLEAR);
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.commit = (state_q == ST_LOOKUP) && (!out_valid_q || !out_stall_i);
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (status_i.clear_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (cmd_o.commit) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_CLEAR;
        end
      endcase
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/set_assoc_lru_cache_sim.sv
// ----------------------------------------------------------------------------
// Set-associative LRU cache
// Each address item is looked up in its set; the result gives hit, fill or
// eviction, the way used and running hit, miss and eviction counts. An item
// is handled in order: the set's valid bits, ranks and tags are read from the
// set memories into registers, then compared, the way picked and the set
// written back. The result sits in an output register, so the next item is
// taken while it waits; a result still held by a stalled output delays the
// write-back. After reset, a clearing pass sweeps the valid and rank memory
// one set a cycle over all sets, and no item is taken until it is done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache_sim #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int WAYS         = salc_pkg::WAYS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [salc_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [salc_pkg::ADDR_W-1:0]      addr_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [salc_pkg::OUTCOME_W-1:0]        outcome_o,
  output logic [salc_pkg::WAY_OUT_W-1:0]        way_used_o,
  output logic [salc_pkg::CNT_W-1:0]            hit_count_o,
  output logic [salc_pkg::CNT_W-1:0]            miss_count_o,
  output logic [salc_pkg::CNT_W-1:0]            evict_count_o
);

  salc_pkg::salc_cmd_t    cmd;
  salc_pkg::salc_status_t status;

  salc_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  salc_datapath #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .WAYS         (WAYS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .addr_i        (addr_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .outcome_o     (outcome_o),
    .way_used_o    (way_used_o),
    .hit_count_o   (hit_count_o),
    .miss_count_o  (miss_count_o),
    .evict_count_o (evict_count_o)
  );

endmodule

`default_nettype wire

### rtl/core/salc_checker.sv
// ----------------------------------------------------------------------------
// Set-associative LRU cache port checker
// Concurrent checks on the cache ports, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "set_assoc_lru_cache_sim_defines.svh"

module salc_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_stall_o,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic [salc_pkg::OUTCOME_W-1:0]   outcome_o,
  input wire logic [salc_pkg::WAY_OUT_W-1:0]   way_used_o,
  input wire logic [salc_pkg::CNT_W-1:0]       hit_count_o
);

  // The block works on one item at a time, so it is busy right after taking one.
  `SALC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A new result only appears at the end of an item's lookup.
  `SALC_ASSERT_SAME(a_result_after_lookup, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

  `SALC_ASSERT_SAME(a_outcome_code, clk_i, rst_ni, out_valid_o, outcome_o == salc_pkg::OUTCOME_HIT || outcome_o == salc_pkg::OUTCOME_FILL || outcome_o == salc_pkg::OUTCOME_EVICT)

  `SALC_ASSERT_NEXT(a_stalled_result_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(outcome_o) && $stable(way_used_o) && $stable(hit_count_o))

endmodule

bind set_assoc_lru_cache_sim salc_checker u_salc_checker (.*);

`default_nettype wire
